// ===== hdl/fm_iq_modulator_assert.svh =====
// Assertion macros used by the modulator RTL.
`ifndef FM_IQ_MODULATOR_ASSERT_SVH
`define FM_IQ_MODULATOR_ASSERT_SVH

// Clocked check that is ignored while reset is asserted.
`define FMIQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define FMIQ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fmiq_pkg.sv =====
package fmiq_pkg;

  localparam int AUDIO_W = 16;
  localparam int DEV_W   = 23;
  localparam int IQ_W    = 8;
  localparam int PHASE_W = 32;
  // A 16-bit signed sample times a 23-bit unsigned deviation is a 40-bit signed product;
  // dropping 15 fraction bits leaves 25 signed bits.
  localparam int STEP_W  = 25;
  localparam int PROD_W  = AUDIO_W + DEV_W + 1;

  localparam logic [DEV_W-1:0] DEV_RESET = 23'd3937053;

  // pi/2 in unsigned Q60.
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

  typedef logic signed [STEP_W-1:0] step_t;
  typedef logic signed [IQ_W-1:0]   iq_t;

  // Divide one Taylor term by n*(n-1) for odd n from 3 to 25.
  function automatic logic [63:0] divide_term(input logic [63:0] term, input int n);
    logic [63:0] res;
    case (n)
      3:       res = term / 64'd6;
      5:       res = term / 64'd20;
      7:       res = term / 64'd42;
      9:       res = term / 64'd72;
      11:      res = term / 64'd110;
      13:      res = term / 64'd156;
      15:      res = term / 64'd210;
      17:      res = term / 64'd272;
      19:      res = term / 64'd342;
      21:      res = term / 64'd420;
      23:      res = term / 64'd506;
      25:      res = term / 64'd600;
      default: res = term;
    endcase
    return res;
  endfunction

  // Rounded 100*sin(k*pi/2/quarter) from a truncated Q31 Taylor series.
  function automatic logic [7:0] quarter_sine(input int unsigned k, input int bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic        subtract;
    x = (((HALF_PI_Q60 >> 17) * 64'(k)) >> (bits - 2)) >> 12;
    term = x;
    pos = x;
    neg = 64'd0;
    subtract = 1'b1;
    for (int n = 3; n <= 25; n += 2) begin
      term = (term * x) >> 31;
      term = (term * x) >> 31;
      term = divide_term(term, n);
      if (subtract) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
      subtract = !subtract;
    end
    s = (pos > neg) ? pos - neg : 64'd0;
    s = (64'd100 * s + (64'd1 << 30)) >> 31;
    if (s > 64'd100) begin
      s = 64'd100;
    end
    return s[7:0];
  endfunction

  // Quarter-wave entry, with both end points pinned.
  function automatic logic [7:0] quarter_entry(input int unsigned k, input int bits);
    logic [7:0] res;
    if (k == 0) begin
      res = 8'd0;
    end else if (k == (32'd1 << (bits - 2))) begin
      res = 8'd100;
    end else begin
      res = quarter_sine(k, bits);
    end
    return res;
  endfunction

  // Full-wave sine entry built from the quarter wave by symmetry.
  function automatic iq_t table_sine(input int unsigned idx, input int bits);
    int unsigned quarter;
    int unsigned quad;
    int unsigned r;
    iq_t         res;
    quarter = 32'd1 << (bits - 2);
    quad = (idx >> (bits - 2)) & 32'd3;
    r = idx & (quarter - 32'd1);
    case (quad)
      0:       res = $signed(quarter_entry(r, bits));
      1:       res = $signed(quarter_entry(quarter - r, bits));
      2:       res = -$signed(quarter_entry(r, bits));
      default: res = -$signed(quarter_entry(quarter - r, bits));
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/fmiq_front.sv =====
module fmiq_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fmiq_pkg::DEV_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [fmiq_pkg::AUDIO_W-1:0] in_audio_sample,
  output logic                              push,
  input  logic                              full,
  output fmiq_pkg::step_t                   step
);

  logic [fmiq_pkg::DEV_W-1:0]         dev_r;
  logic                               stage_valid_r;
  fmiq_pkg::step_t                    stage_step_r;
  logic signed [fmiq_pkg::PROD_W-1:0] prod;
  logic                               accept;

  // Deviation register, written directly by the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= fmiq_pkg::DEV_RESET;
    end else if (cfg_we) begin
      dev_r <= cfg_wdata;
    end
  end

  // Signed product; the arithmetic shift by 15 is a plain part-select.
  assign prod = in_audio_sample * $signed({1'b0, dev_r});

  assign in_ready = !stage_valid_r || !full;
  assign accept   = in_valid && in_ready;
  assign push     = stage_valid_r && !full;
  assign step     = stage_step_r;

  // One holding stage between the multiplier and the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (accept) begin
      stage_valid_r <= 1'b1;
    end else if (push) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_step_r <= $signed(prod[fmiq_pkg::PROD_W-1:15]);
    end
  end

endmodule

// ===== hdl/fmiq_queue.sv =====
module fmiq_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fmiq_pkg::step_t push_step,
  input  logic            pop,
  output fmiq_pkg::step_t head,
  output logic            full,
  output logic            empty
);

  fmiq_pkg::step_t entry_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = entry_r[rd_ptr_r];

  // Pointers and fill count of the two-entry step queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_step;
    end
  end

endmodule

// ===== hdl/fmiq_back.sv =====
module fmiq_back #(
  parameter int OUTPUTS_PER_SAMPLE = 50,
  parameter int SINE_TABLE_BITS    = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  fmiq_pkg::step_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output fmiq_pkg::iq_t   out_i_value,
  output fmiq_pkg::iq_t   out_q_value,
  output logic            out_last_of_sample
);

  localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;
  localparam int QUARTER    = 1 << (SINE_TABLE_BITS - 2);
  localparam int CNT_W      = (OUTPUTS_PER_SAMPLE > 1) ? $clog2(OUTPUTS_PER_SAMPLE) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OUTPUTS_PER_SAMPLE - 1);

  logic                              active_r;
  logic [CNT_W-1:0]                  cnt_r;
  fmiq_pkg::step_t                   step_r;
  logic [fmiq_pkg::PHASE_W-1:0]      phase_r;
  logic                              s1_valid_r;
  logic                              s1_last_r;
  fmiq_pkg::iq_t                     rd_i_r;
  fmiq_pkg::iq_t                     rd_q_r;
  logic                              out_valid_r;
  fmiq_pkg::iq_t                     out_i_r;
  fmiq_pkg::iq_t                     out_q_r;
  logic                              out_last_r;
  logic                              out_load;
  logic                              s1_adv;
  logic                              issue;
  logic                              at_last;
  logic                              last_issue;
  logic [SINE_TABLE_BITS-1:0]        sin_idx;
  logic [SINE_TABLE_BITS-1:0]        cos_idx;
  fmiq_pkg::iq_t                     sine_rom [TABLE_SIZE];

  // Sine ROM contents are fixed at elaboration.
  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
    assign sine_rom[g] = fmiq_pkg::table_sine(g, SINE_TABLE_BITS);
  end

  // Pipeline flow: output register, ROM read stage, pair generator.
  assign out_load   = !out_valid_r || out_ready;
  assign s1_adv     = !s1_valid_r || out_load;
  assign issue      = active_r && s1_adv;
  assign at_last    = (cnt_r == CNT_LAST);
  assign last_issue = issue && at_last;
  assign q_pop      = !q_empty && (!active_r || last_issue);

  // Cosine is read a quarter turn ahead; the index wraps on its own.
  assign sin_idx = phase_r[fmiq_pkg::PHASE_W-1 -: SINE_TABLE_BITS];
  assign cos_idx = sin_idx + SINE_TABLE_BITS'(QUARTER);

  // Pair generator: phase accumulator and pair counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
      phase_r  <= '0;
    end else begin
      if (issue) begin
        phase_r <= phase_r + fmiq_pkg::PHASE_W'(step_r);
        cnt_r   <= at_last ? '0 : cnt_r + CNT_W'(1);
      end
      if (q_pop) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (last_issue) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      step_r <= q_head;
    end
  end

  // Registered ROM read, two addresses per cycle whenever the stage can advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rd_q_r    <= sine_rom[sin_idx];
      rd_i_r    <= sine_rom[cos_idx];
      s1_last_r <= at_last;
    end
  end

  // Output register toward the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_i_r    <= rd_i_r;
      out_q_r    <= rd_q_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_i_value        = out_i_r;
  assign out_q_value        = out_q_r;
  assign out_last_of_sample = out_last_r;

endmodule

// ===== hdl/fm_iq_modulator.sv =====
// The first I/Q pair of a sample passes through the front holding stage, step queue,
// step register of the pair generator, ROM read register and output register.
// Throughput: one pair per cycle while out_ready stays high, OUTPUTS_PER_SAMPLE (50 by
// default) pairs per sample, set by the pair generator and its two-port sine ROM read.
// Reset (rst_n, synchronous, active low): phase accumulator to zero, deviation step to
// 3937053, step queue and all pipeline stages empty; no clearing pass is needed.
`include "fm_iq_modulator_assert.svh"

module fm_iq_modulator #(
  parameter int OUTPUTS_PER_SAMPLE = 50,
  parameter int SINE_TABLE_BITS    = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fmiq_pkg::DEV_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [fmiq_pkg::AUDIO_W-1:0] in_audio_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fmiq_pkg::IQ_W-1:0]    out_i_value,
  output logic signed [fmiq_pkg::IQ_W-1:0]    out_q_value,
  output logic                                out_last_of_sample
);

  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  fmiq_pkg::step_t front_step;
  fmiq_pkg::step_t q_head;

  // Front end: deviation register, step multiply, holding stage.
  fmiq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_audio_sample (in_audio_sample),
    .push            (q_push),
    .full            (q_full),
    .step            (front_step)
  );

  // Short step queue that decouples the two halves.
  fmiq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_step (front_step),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: phase accumulator, sine ROM, output register.
  fmiq_back #(
    .OUTPUTS_PER_SAMPLE (OUTPUTS_PER_SAMPLE),
    .SINE_TABLE_BITS    (SINE_TABLE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_i_value        (out_i_value),
    .out_q_value        (out_q_value),
    .out_last_of_sample (out_last_of_sample)
  );

  // The front end never writes into a full queue.
  `FMIQ_ASSERT(a_no_overflow, q_push |-> !q_full, "step queue overflow")
  // The back end never takes a step from an empty queue.
  `FMIQ_ASSERT(a_no_underflow, q_pop |-> !q_empty, "step queue underflow")
  // Reset leaves no result pending.
  `FMIQ_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

// ===== test/tb_top.sv =====
module tb_top;

  localparam int PAIRS_PER_SAMPLE = 50;
  localparam int TAB_BITS         = 10;
  localparam int QUARTER          = 1 << (TAB_BITS - 2);
  localparam int DRAIN_CYCLES     = 12;
  localparam int HOLD_AT_SAMPLE   = 110;
  localparam int HOLD_CYCLES      = 600;

  localparam logic [fmiq_pkg::DEV_W-1:0] DEV_LOW  = 23'd894785;
  localparam logic [fmiq_pkg::DEV_W-1:0] DEV_HIGH = 23'd7158279;

  // Opening samples: full scale both ways, zero, one LSB each way, bit patterns.
  localparam logic signed [fmiq_pkg::AUDIO_W-1:0] OPENING_AUDIO [0:17] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF,
    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h8000,
    16'h8000, 16'h8001, 16'h4000, 16'hC000, 16'h00FF, 16'hFF00
  };

  typedef struct packed {
    fmiq_pkg::iq_t i_val;
    fmiq_pkg::iq_t q_val;
    logic          last;
  } iq_pair_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [fmiq_pkg::DEV_W-1:0]          cfg_wdata = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [fmiq_pkg::AUDIO_W-1:0] in_audio_sample = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  fmiq_pkg::iq_t                       out_i_value;
  fmiq_pkg::iq_t                       out_q_value;
  logic                                out_last_of_sample;

  // Samples waiting to be offered, and I/Q pairs predicted but not yet seen.
  logic signed [fmiq_pkg::AUDIO_W-1:0] audio_backlog [$];
  iq_pair_t                            iq_pairs_due [$];

  // Predictor state: deviation register copy, phase accumulator, quarter-wave table.
  logic [fmiq_pkg::DEV_W-1:0]          dev_model = fmiq_pkg::DEV_RESET;
  logic [fmiq_pkg::PHASE_W-1:0]        nco_phase = '0;
  int                                  quarter_wave [0:QUARTER];

  int unsigned                bad_count = 0;
  int unsigned                samples_sent = 0;
  int unsigned                gap_left = 0;
  int unsigned                stall_left = 0;
  int unsigned                hold_left = 0;
  logic                       hold_done = 1'b0;
  int unsigned                calm_left = 0;

  fm_iq_modulator #(
    .OUTPUTS_PER_SAMPLE(PAIRS_PER_SAMPLE),
    .SINE_TABLE_BITS   (TAB_BITS)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_audio_sample   (in_audio_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_i_value       (out_i_value),
    .out_q_value       (out_q_value),
    .out_last_of_sample(out_last_of_sample)
  );

  always #1 clk = ~clk;

  // Length of one idle stretch: mostly short, now and then a long one.
  function automatic int unsigned idle_span();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return $urandom_range(1, 3);
    end else if (pick < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(30, 120);
  endfunction

  // Full-wave sine from the quarter wave: bit 0 of the quadrant mirrors, bit 1 negates.
  function automatic fmiq_pkg::iq_t sine_at(input logic [TAB_BITS-1:0] idx);
    logic [1:0] quad;
    int         r;
    int         mag;
    quad = idx[TAB_BITS-1 -: 2];
    r = int'(idx[TAB_BITS-3:0]);
    if (quad[0]) begin
      r = QUARTER - r;
    end
    mag = quarter_wave[r];
    return fmiq_pkg::iq_t'(quad[1] ? -mag : mag);
  endfunction

  // Quarter-wave table: truncated Q31 Taylor series, rounded half up, ends pinned.
  initial begin : build_quarter_wave
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic        subtract;
    for (int k = 0; k <= QUARTER; k++) begin
      x = (((fmiq_pkg::HALF_PI_Q60 >> 17) * 64'(k)) >> (TAB_BITS - 2)) >> 12;
      term = x;
      pos = x;
      neg = '0;
      subtract = 1'b1;
      for (int n = 3; n <= 25; n += 2) begin
        term = (term * x) >> 31;
        term = (term * x) >> 31;
        term = term / 64'((n - 1) * n);
        if (subtract) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
        subtract = !subtract;
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      s = (64'd100 * s + (64'd1 << 30)) >> 31;
      if (s > 64'd100) begin
        s = 64'd100;
      end
      quarter_wave[k] = int'(s);
    end
    quarter_wave[0] = 0;
    quarter_wave[QUARTER] = 100;
  end

  // Shared quiet periods in which neither side starts a new random idle stretch.
  always @(posedge clk) begin
    if (calm_left != 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 399) == 0) begin
      calm_left <= $urandom_range(100, 400);
    end
  end

  // Sample driver: holds the payload until its transfer, then waits out a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_ready) begin
      in_valid <= 1'b1;
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (audio_backlog.size() != 0) begin
      in_valid <= 1'b1;
      in_audio_sample <= audio_backlog.pop_front();
      gap_left <= (calm_left != 0 || $urandom_range(0, 1) == 0) ? 0 : idle_span();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: one long hold-off to fill the block, random stalls otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && samples_sent >= HOLD_AT_SAMPLE) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm_left == 0 && $urandom_range(0, 99) < 12) begin
      out_ready <= 1'b0;
      stall_left <= idle_span() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each output transfer against the oldest prediction, then predict the
  // pairs of any sample transferred at this edge.
  always @(posedge clk) begin : predict_and_check
    iq_pair_t                     want;
    iq_pair_t                     pair;
    longint                       prod;
    logic [fmiq_pkg::PHASE_W-1:0] step;
    logic [TAB_BITS-1:0]          idx;
    logic [TAB_BITS-1:0]          cos_idx;
    if (!rst_n) begin
      nco_phase = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (iq_pairs_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("unexpected pair: i=%0d q=%0d last=%0b",
                     out_i_value, out_q_value, out_last_of_sample);
          end
        end else begin
          want = iq_pairs_due.pop_front();
          if (out_i_value !== want.i_val || out_q_value !== want.q_val ||
              out_last_of_sample !== want.last) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("mismatch: exp i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                       want.i_val, want.q_val, want.last,
                       out_i_value, out_q_value, out_last_of_sample);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        // The arithmetic shift floors the product, as the block does.
        prod = longint'(in_audio_sample) * longint'(dev_model);
        step = fmiq_pkg::PHASE_W'(prod >>> 15);
        for (int k = 0; k < PAIRS_PER_SAMPLE; k++) begin
          idx = nco_phase[fmiq_pkg::PHASE_W-1 -: TAB_BITS];
          cos_idx = idx + TAB_BITS'(QUARTER);
          pair.i_val = sine_at(cos_idx);
          pair.q_val = sine_at(idx);
          pair.last = (k == PAIRS_PER_SAMPLE - 1);
          iq_pairs_due.push_back(pair);
          nco_phase = nco_phase + step;
        end
        samples_sent <= samples_sent + 1;
      end
    end
  end

  // Wait until every queued sample has its transfer and every pair has arrived.
  task automatic wait_drained();
    while (audio_backlog.size() != 0 || in_valid || iq_pairs_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write while the block is idle; the model copy follows it.
  task automatic write_deviation(input logic [fmiq_pkg::DEV_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    dev_model <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly full-range samples, some near zero, some at the corners.
  task automatic queue_random(input int count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        audio_backlog.push_back(fmiq_pkg::AUDIO_W'($urandom()));
      end else if (pick < 85) begin
        audio_backlog.push_back(fmiq_pkg::AUDIO_W'($urandom_range(0, 64) - 32));
      end else begin
        audio_backlog.push_back(OPENING_AUDIO[$urandom_range(0, 1)] +
                                fmiq_pkg::AUDIO_W'(pick & 1));
      end
    end
  endtask

  // Stimulus phases, each at its own deviation setting.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset deviation, directed samples.
    foreach (OPENING_AUDIO[j]) begin
      audio_backlog.push_back(OPENING_AUDIO[j]);
    end
    wait_drained();

    write_deviation(DEV_LOW);
    queue_random(60);
    wait_drained();

    // Largest 23-bit step: full scale each way, then random.
    write_deviation({fmiq_pkg::DEV_W{1'b1}});
    repeat (6) audio_backlog.push_back(16'sh7FFF);
    repeat (6) audio_backlog.push_back(-16'sh8000);
    queue_random(60);
    wait_drained();

    write_deviation(DEV_HIGH);
    queue_random(60);
    wait_drained();

    write_deviation('0);
    queue_random(20);
    wait_drained();

    write_deviation(fmiq_pkg::DEV_W'($urandom()));
    queue_random(60);
    wait_drained();

    write_deviation(fmiq_pkg::DEV_W'($urandom_range(DEV_LOW, DEV_HIGH)));
    queue_random(20);
    wait_drained();

    if (bad_count == 0 && iq_pairs_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #100000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
